// ===== hdl/sdboot_pkg.sv =====
package sdboot_pkg;

    localparam int SECTOR_BYTES    = 512;
    localparam int POWERON_DUMMIES = 20;
    localparam int OFFSET_WIDTH    = 16;

    typedef enum logic [2:0] {
        K_NONE   = 3'd0,
        K_CMD0   = 3'd1,
        K_CMD8   = 3'd2,
        K_CMD55  = 3'd3,
        K_ACMD41 = 3'd4,
        K_CMD58  = 3'd5,
        K_CMD16  = 3'd6,
        K_CMD17  = 3'd7
    } cmd_t;

    typedef enum logic [2:0] {
        S_SEND  = 3'd0,
        S_POLL  = 3'd1,
        S_TAIL  = 3'd2,
        S_END   = 3'd3,
        S_TOKEN = 3'd4,
        S_DATA  = 3'd5,
        S_RSV6  = 3'd6,
        S_RSV7  = 3'd7
    } sub_t;

    localparam logic [3:0] ST_BUSY   = 4'd0;
    localparam logic [3:0] ST_LOADED = 4'd1;
    localparam logic [3:0] ST_CMD0   = 4'd2;
    localparam logic [3:0] ST_CMD8   = 4'd3;
    localparam logic [3:0] ST_ACMD41 = 4'd4;
    localparam logic [3:0] ST_CMD58  = 4'd5;
    localparam logic [3:0] ST_HEADER = 4'd6;
    localparam logic [3:0] ST_SIZE   = 4'd7;
    localparam logic [3:0] ST_SECTOR = 4'd8;

    localparam logic [2:0] REG_START_SECTOR = 3'd0;
    localparam logic [2:0] REG_MAX_IMAGE    = 3'd1;
    localparam logic [2:0] REG_RESP_LIMIT   = 3'd2;
    localparam logic [2:0] REG_TOKEN_LIMIT  = 3'd3;
    localparam logic [2:0] REG_INIT_DIV     = 3'd4;
    localparam logic [2:0] REG_RUN_DIV      = 3'd5;

    function automatic logic [7:0] cmd_code(input cmd_t k);
        case (k)
            K_CMD0:   cmd_code = 8'h40;
            K_CMD8:   cmd_code = 8'h48;
            K_CMD55:  cmd_code = 8'h77;
            K_ACMD41: cmd_code = 8'h69;
            K_CMD58:  cmd_code = 8'h7A;
            K_CMD16:  cmd_code = 8'h50;
            K_CMD17:  cmd_code = 8'h51;
            default:  cmd_code = 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] cmd_crc(input cmd_t k);
        case (k)
            K_CMD0:   cmd_crc = 8'h95;
            K_CMD8:   cmd_crc = 8'h87;
            K_CMD55:  cmd_crc = 8'h65;
            K_ACMD41: cmd_crc = 8'h77;
            K_CMD58:  cmd_crc = 8'hFD;
            K_CMD16:  cmd_crc = 8'h15;
            K_CMD17:  cmd_crc = 8'h01;
            default:  cmd_crc = 8'h00;
        endcase
    endfunction

    function automatic logic [31:0] cmd_arg(input cmd_t k);
        case (k)
            K_CMD8:   cmd_arg = 32'h0000_01AA;
            K_ACMD41: cmd_arg = 32'h4000_0000;
            K_CMD16:  cmd_arg = 32'h0000_0200;
            default:  cmd_arg = 32'h0;
        endcase
    endfunction

endpackage

// ===== hdl/sd_spi_boot_loader_top.sv =====
// SD-card SPI-mode boot sequencer. A start transfer (func 0) runs the whole
// boot: power-on dummies with chip select high, CMD0, CMD8, CMD55/ACMD41 while
// idle, CMD58, CMD16, then CMD17 sector reads from start_sector. Every
// completed byte exchange (func 1) that arrives while a sequence runs yields
// exactly one result transfer: the next exchange request (with an optional
// image byte write) or the final status. Completions while idle are dropped.
// One input transfer can be taken every clock while s_tready is high, and its
// result transfer is offered from the result register. While a result waits, a
// skid register takes one more input transfer; s_tready then drops until the
// receiver drains the result register. Configuration writes take effect at
// their next use and are meant to happen only while the block is idle.
module sd_spi_boot_loader_top
    import sdboot_pkg::*;
#(
    parameter int PowerOnDummies = POWERON_DUMMIES,
    parameter int OffsetWidth    = OFFSET_WIDTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // rx_byte
    input  logic        s_tuser,   // func
    output logic        m_tvalid,
    input  logic        m_tready,
    // xfer_request, tx_byte, cs_high, clock_divider, write_enable,
    // write_offset, write_data, status (zero filled to whole bytes)
    output logic [((31 + OffsetWidth + 7) / 8) * 8 - 1:0] m_tdata
);

    localparam int OutW = 31 + OffsetWidth;
    localparam int OutB = ((OutW + 7) / 8) * 8;

    // configuration
    logic [31:0] start_sector_reg;
    logic [15:0] max_image_reg;
    logic [9:0]  resp_limit_reg;
    logic [16:0] token_limit_reg;
    logic [7:0]  init_div_reg, run_div_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_sector_reg <= 32'd2048;
            max_image_reg    <= 16'd61440;
            resp_limit_reg   <= 10'd1000;
            token_limit_reg  <= 17'd100000;
            init_div_reg     <= 8'd199;
            run_div_reg      <= 8'd3;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_START_SECTOR: start_sector_reg <= cfg_data;
                REG_MAX_IMAGE:    max_image_reg    <= cfg_data[15:0];
                REG_RESP_LIMIT:   resp_limit_reg   <= cfg_data[9:0];
                REG_TOKEN_LIMIT:  token_limit_reg  <= cfg_data[16:0];
                REG_INIT_DIV:     init_div_reg     <= cfg_data[7:0];
                REG_RUN_DIV:      run_div_reg      <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // sequencer state
    logic        active_reg, active_next;
    cmd_t        k_reg, k_next;
    sub_t        sub_reg, sub_next;
    logic [9:0]  bidx_reg, bidx_next;
    logic [16:0] poll_reg, poll_next;
    logic [7:0]  lastr_reg, lastr_next;
    logic        chk_reg, chk_next;
    logic        hc_reg, hc_next;
    logic [31:0] sector_reg, sector_next;
    logic [31:0] size_reg, size_next;
    logic [15:0] written_reg, written_next;

    // output stage: main result register plus skid
    logic            out_v_reg, skid_v_reg;
    logic [OutW-1:0] out_d_reg, skid_d_reg;

    assign s_tready = !skid_v_reg;
    logic accept;
    assign accept = s_tvalid && s_tready;

    logic            emit;
    logic [OutW-1:0] res;

    always_comb
    begin
        logic [7:0]  rx;
        logic        fin, we;
        logic [3:0]  code;
        logic [16:0] lim;
        logic        valid_sz;
        logic [31:0] arg;
        logic [7:0]  tx, div;
        logic        cs;
        logic [OffsetWidth-1:0] off;
        logic [7:0]  wdata;
        logic        gov;
        cmd_t        gk;
        sub_t        gs;

        rx = s_tdata;
        active_next = active_reg; k_next = k_reg; sub_next = sub_reg;
        bidx_next = bidx_reg; poll_next = poll_reg; lastr_next = lastr_reg;
        chk_next = chk_reg; hc_next = hc_reg; sector_next = sector_reg;
        size_next = size_reg; written_next = written_reg;
        fin = 1'b0; code = ST_BUSY; we = 1'b0; wdata = 8'd0;
        off = '0; emit = 1'b0; gov = 1'b0; gk = k_reg; gs = sub_reg;
        lim = 17'd1; valid_sz = 1'b0;

        if (accept)
        begin
            if (!s_tuser)
            begin
                emit = 1'b1; active_next = 1'b1;
                k_next = K_NONE; sub_next = S_POLL; bidx_next = '0; poll_next = '0;
                lastr_next = '0; chk_next = 1'b0; hc_next = 1'b0;
                sector_next = '0; size_next = '0; written_next = '0;
            end
            else if (active_reg)
            begin
                emit = 1'b1;
                if (k_reg == K_NONE)
                begin
                    if (32'(bidx_reg) + 32'd1 >= 32'(PowerOnDummies))
                    begin
                        gov = 1'b1; gk = K_CMD0; gs = S_SEND;
                    end
                    else
                        bidx_next = bidx_reg + 10'd1;
                end
                else
                begin
                    case (sub_reg)
                        S_SEND:
                        begin
                            if (bidx_reg >= 10'd6)
                            begin
                                gov = 1'b1; gs = S_POLL;
                            end
                            else
                                bidx_next = bidx_reg + 10'd1;
                        end
                        S_POLL:
                        begin
                            logic        got;
                            logic [7:0]  r;
                            lim = (resp_limit_reg == '0) ? 17'd1 : 17'(resp_limit_reg);
                            got = 1'b0; r = 8'hFF;
                            if (!rx[7])
                            begin
                                got = 1'b1; r = rx;
                            end
                            else if (poll_reg + 17'd1 >= lim)
                                got = 1'b1;
                            else
                                poll_next = poll_reg + 17'd1;
                            if (got)
                            begin
                                lastr_next = r; chk_next = 1'b0; gov = 1'b1;
                                if (k_reg == K_CMD8 && r == 8'd1)
                                    gs = S_TAIL;
                                else if (k_reg == K_CMD58)
                                    gs = S_TAIL;
                                else if (k_reg == K_CMD17 && r == 8'd0)
                                    gs = S_TOKEN;
                                else
                                    gs = S_END;
                            end
                        end
                        S_TAIL:
                        begin
                            if (k_reg == K_CMD8)
                            begin
                                if (bidx_reg == 10'd2)
                                    chk_next = (rx[3:0] == 4'd1);
                                else if (bidx_reg == 10'd3)
                                    chk_next = chk_reg && (rx == 8'hAA);
                            end
                            else if (bidx_reg == 10'd0 && lastr_reg == 8'd0)
                            begin
                                chk_next = rx[7];
                                if (rx[7])
                                    hc_next = rx[6];
                            end
                            if (bidx_reg >= 10'd3)
                            begin
                                gov = 1'b1; gs = S_END;
                            end
                            else
                                bidx_next = bidx_reg + 10'd1;
                        end
                        S_TOKEN:
                        begin
                            lim = (token_limit_reg == '0) ? 17'd1 : token_limit_reg;
                            poll_next = poll_reg + 17'd1;
                            if (poll_reg + 17'd1 >= lim)
                            begin
                                chk_next = 1'b0; gov = 1'b1; gs = S_END;
                            end
                            else if (rx == 8'hFE)
                            begin
                                gov = 1'b1; gs = S_DATA;
                            end
                        end
                        S_DATA:
                        begin
                            // payload window: bytes 0..511, then two CRC bytes
                            if (bidx_reg < 10'(SECTOR_BYTES))
                            begin
                                if (written_reg == '0 && bidx_reg < 10'd4)
                                begin
                                    case (bidx_reg[1:0])
                                        2'd0: size_next[7:0]   = size_reg[7:0]   | rx;
                                        2'd1: size_next[15:8]  = size_reg[15:8]  | rx;
                                        2'd2: size_next[23:16] = size_reg[23:16] | rx;
                                        default:
                                            size_next[31:24] = size_reg[31:24] | rx;
                                    endcase
                                end
                                else
                                begin
                                    valid_sz = (size_reg != '0) &&
                                               (size_reg <= 32'(max_image_reg));
                                    if ((written_reg != '0 || valid_sz) &&
                                        32'(written_reg) < size_reg)
                                    begin
                                        we = 1'b1;
                                        off = OffsetWidth'(written_reg);
                                        wdata = rx;
                                        written_next = written_reg + 16'd1;
                                    end
                                end
                            end
                            if (bidx_reg + 10'd1 >= 10'(SECTOR_BYTES + 2))
                            begin
                                chk_next = 1'b1; gov = 1'b1; gs = S_END;
                            end
                            else
                                bidx_next = bidx_reg + 10'd1;
                        end
                        S_END:
                        begin
                            case (k_reg)
                                K_CMD0:
                                    if (lastr_reg != 8'd1)
                                    begin
                                        fin = 1'b1; code = ST_CMD0;
                                    end
                                    else
                                    begin
                                        gov = 1'b1; gk = K_CMD8; gs = S_SEND;
                                    end
                                K_CMD8:
                                    if (lastr_reg != 8'd1 || !chk_reg)
                                    begin
                                        fin = 1'b1; code = ST_CMD8;
                                    end
                                    else
                                    begin
                                        gov = 1'b1; gk = K_CMD55; gs = S_SEND;
                                    end
                                K_CMD55:
                                begin
                                    gov = 1'b1; gk = K_ACMD41; gs = S_SEND;
                                end
                                K_ACMD41:
                                    if (lastr_reg == 8'd1)
                                    begin
                                        gov = 1'b1; gk = K_CMD55; gs = S_SEND;
                                    end
                                    else if (lastr_reg == 8'd0)
                                    begin
                                        gov = 1'b1; gk = K_CMD58; gs = S_SEND;
                                    end
                                    else
                                    begin
                                        fin = 1'b1; code = ST_ACMD41;
                                    end
                                K_CMD58:
                                    if (lastr_reg != 8'd0 || !chk_reg)
                                    begin
                                        fin = 1'b1; code = ST_CMD58;
                                    end
                                    else
                                    begin
                                        gov = 1'b1; gk = K_CMD16; gs = S_SEND;
                                    end
                                K_CMD16:
                                begin
                                    sector_next = start_sector_reg;
                                    gov = 1'b1; gk = K_CMD17; gs = S_SEND;
                                end
                                default:
                                    if (!chk_reg)
                                    begin
                                        fin = 1'b1;
                                        code = (written_reg == '0) ? ST_HEADER : ST_SECTOR;
                                    end
                                    else if (written_reg == '0)
                                    begin
                                        fin = 1'b1; code = ST_SIZE;
                                    end
                                    else if (32'(written_reg) >= size_reg)
                                    begin
                                        fin = 1'b1; code = ST_LOADED;
                                    end
                                    else
                                    begin
                                        sector_next = sector_reg + 32'd1;
                                        gov = 1'b1; gk = K_CMD17; gs = S_SEND;
                                    end
                            endcase
                        end
                        default:
                        begin
                            // unused sub-phase: drop to idle silently
                            emit = 1'b0; active_next = 1'b0;
                        end
                    endcase
                end
                if (gov)
                begin
                    k_next = gk; sub_next = gs; bidx_next = '0; poll_next = '0;
                end
                if (fin)
                    active_next = 1'b0;
            end
        end

        // build the result from the state the step leaves
        tx = 8'hFF; cs = 1'b0;
        div = (k_next == K_CMD17) ? run_div_reg : init_div_reg;
        arg = cmd_arg(k_next);
        if (k_next == K_CMD17)
            arg = hc_next ? sector_next : {sector_next[22:0], 9'd0};
        if (k_next == K_NONE)
            cs = 1'b1;
        else if (sub_next == S_SEND)
        begin
            case (bidx_next)
                10'd1: tx = cmd_code(k_next);
                10'd2: tx = arg[31:24];
                10'd3: tx = arg[23:16];
                10'd4: tx = arg[15:8];
                10'd5: tx = arg[7:0];
                10'd6: tx = cmd_crc(k_next);
                default: tx = 8'hFF;
            endcase
        end
        else if (sub_next == S_END && k_next == K_CMD17)
            cs = 1'b1;

        if (fin)
        begin
            div = (code >= ST_CMD0 && code <= ST_CMD58) ? init_div_reg : run_div_reg;
            res = {code, 8'd0, {OffsetWidth{1'b0}}, 1'b0, div, 1'b1, 8'd0, 1'b0};
        end
        else
            res = {ST_BUSY, wdata, off, we, div, cs, tx, 1'b1};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0; k_reg <= K_NONE; sub_reg <= S_SEND;
            bidx_reg <= '0; poll_reg <= '0; lastr_reg <= '0;
            chk_reg <= 1'b0; hc_reg <= 1'b0; sector_reg <= '0;
            size_reg <= '0; written_reg <= '0;
        end
        else
        begin
            active_reg <= active_next; k_reg <= k_next; sub_reg <= sub_next;
            bidx_reg <= bidx_next; poll_reg <= poll_next; lastr_reg <= lastr_next;
            chk_reg <= chk_next; hc_reg <= hc_next; sector_reg <= sector_next;
            size_reg <= size_next; written_reg <= written_next;
        end
    end

    // result register with skid: a new result lands in the skid register
    // only when the main one is full and not being drained
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else
        begin
            if (!out_v_reg || m_tready)
            begin
                if (skid_v_reg)
                begin
                    out_v_reg  <= 1'b1;
                    skid_v_reg <= 1'b0;
                end
                else
                    out_v_reg <= emit;
            end
            else if (emit)
                skid_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_v_reg || m_tready)
            out_d_reg <= skid_v_reg ? skid_d_reg : res;
        if (emit && out_v_reg && !m_tready)
            skid_d_reg <= res;
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = OutB'(out_d_reg);

endmodule
